// ----- design/kcv_pkg.sv -----
// ----------------------------------------------------------------------------
// kcv_pkg: shared types and constants for the 3D constant-velocity filter
// Fixed-point widths, datapath command/status structs and register indexes.
// ----------------------------------------------------------------------------
package kcv_pkg;

  // Q16.16 state words; ports are 32 bits and match the state width
  localparam int DW  = 32;
  localparam int FB  = 16;
  localparam int MW  = DW + 1;       // magnitude of a difference of two state words
  localparam int PW  = 2 * MW;       // full product / sum-of-squares width
  localparam int QW  = 64;           // divider numerator and quotient width
  localparam int DVW = DW + 2;       // divider denominator width
  localparam int RW  = PW / 2;       // square root result width
  localparam int SW  = DW + 8;       // headroom for multi-operand sums
  localparam int JW  = 31;           // gate and step limit register width
  localparam int CW  = 32;           // config data width
  localparam int CIW = 2;            // config index width

  // config register indexes
  localparam logic [CIW-1:0] REG_PNOISE = 2'd0;
  localparam logic [CIW-1:0] REG_MNOISE = 2'd1;
  localparam logic [CIW-1:0] REG_MJUMP  = 2'd2;
  localparam logic [CIW-1:0] REG_MSTEP  = 2'd3;

  // config reset values
  localparam logic [CW-1:0] PNOISE_RST = 32'd655;
  localparam logic [CW-1:0] MNOISE_RST = 32'd6554;
  localparam logic [JW-1:0] MJUMP_RST  = 31'd3276800;
  localparam logic [JW-1:0] MSTEP_RST  = 31'd655360;

  // axis selects
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // multiplier operand selection
  typedef enum logic [3:0] {
    M_NONE, M_SQD, M_JMP, M_STP, M_KPD, M_KVD, M_KVPV, M_KPPP, M_KPPV, M_DSTEP
  } msel_e;

  // where the registered product goes
  typedef enum logic [2:0] {
    W_NONE, W_ACCL, W_ACC, W_EPOS, W_EVEL, W_VV, W_PP, W_PV
  } wsel_e;

  // single-cycle datapath actions
  typedef enum logic [3:0] {
    A_NONE, A_SEED, A_PRED, A_DIFF_M, A_REJECT, A_DIVKP, A_KPSAVE, A_DIVKV,
    A_KVSAVE, A_DIFF_F, A_SQRT, A_NRMSAVE, A_DIVSTP, A_STPSAVE, A_COMMIT
  } act_e;

  typedef struct packed {
    act_e        act;
    msel_e       msel;
    logic [1:0]  max;   // axis for the multiplier / action
    wsel_e       wsel;
    logic [1:0]  wax;   // axis for the product write-back
  } cmd_t;

  typedef struct packed {
    logic seeded;
    logic acc_lt_prod;
    logic prod_lt_acc;
    logic s_pos;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } stat_t;

endpackage

// ----- design/kalman_cv3d_gated_rate_limited.sv -----
// ----------------------------------------------------------------------------
// kalman_cv3d_gated_rate_limited: gated, step-limited 3D constant-velocity filter
// Q16.16 position filter with a shared scalar covariance, measurement gate
// and an output step clamp.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o   meas_x_i, meas_y_i, meas_z_i
//   out      out  out_valid_o / out_stall_i out_x_o, out_y_o, out_z_o, meas_used_o
//   cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item at a time. The first item is seeded and sent out. Later items are
// predicted and gated; a gated-in item is corrected with two divides when the
// innovation variance is positive, and a step over the limit is clamped with
// a square root and three divides. The shared bit-serial divider serves both;
// a stalled output beat holds the next item in its commit state. in_stall_o
// is high while an item is in flight; a finished beat waiting in the output
// register does not block the next input. Reset clears state and config to
// defaults; no clearing pass.
// ----------------------------------------------------------------------------
module kalman_cv3d_gated_rate_limited (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [31:0]       meas_x_i,
  input  logic signed [31:0]       meas_y_i,
  input  logic signed [31:0]       meas_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [31:0]       out_x_o,
  output logic signed [31:0]       out_y_o,
  output logic signed [31:0]       out_z_o,
  output logic                     meas_used_o,
  input  logic                     cfg_we_i,
  input  logic [kcv_pkg::CIW-1:0]  cfg_idx_i,
  input  logic [kcv_pkg::CW-1:0]   cfg_data_i
);
  import kcv_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;
  logic  load;

  assign in_stall_o = busy;
  assign load       = in_valid_i && !busy;

  kcv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  kcv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .meas_x_i    (meas_x_i),
    .meas_y_i    (meas_y_i),
    .meas_z_i    (meas_z_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .meas_used_o (meas_used_o)
  );

endmodule

// ----- design/kcv_div.sv -----
// ----------------------------------------------------------------------------
// kcv_div: restoring unsigned divider
// One quotient bit per cycle; a division yields QW quotient bits.
// ----------------------------------------------------------------------------
module kcv_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kcv_pkg::QW-1:0]    num_i,
  input  logic [kcv_pkg::DVW-1:0]   den_i,
  output logic                      busy_o,
  output logic [kcv_pkg::QW-1:0]    quot_o
);
  import kcv_pkg::*;

  localparam int CNTW = $clog2(QW + 1);

  logic [CNTW-1:0] cnt_q;
  logic [QW-1:0]   num_q;
  logic [DVW-1:0]  rem_q;
  logic [DVW-1:0]  den_q;
  logic [DVW:0]    rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, num_q[QW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  // iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNTW'(QW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  // shift/subtract; quotient bits enter the numerator register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[QW-2:0], ge};
      rem_q <= ge ? DVW'(rem_sh - {1'b0, den_q}) : rem_sh[DVW-1:0];
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = num_q;

endmodule

// ----- design/kcv_sqrt.sv -----
// ----------------------------------------------------------------------------
// kcv_sqrt: digit-by-digit integer square root
// Floor root of a PW-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module kcv_sqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [kcv_pkg::PW-1:0]  rad_i,
  output logic                    busy_o,
  output logic [kcv_pkg::RW-1:0]  root_o
);
  import kcv_pkg::*;

  localparam int CNTW = $clog2(RW + 1);
  localparam int REMW = RW + 2;

  logic [CNTW-1:0] cnt_q;
  logic [PW-1:0]   rad_q;
  logic [REMW-1:0] rem_q;
  logic [RW-1:0]   root_q;
  logic [REMW+1:0] rem_sh;
  logic [REMW+1:0] trial;
  logic            ge;

  assign rem_sh = {rem_q, rad_q[PW-1:PW-2]};
  assign trial  = (REMW+2)'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  // iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNTW'(RW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  // two radicand bits per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[PW-3:0], 2'b00};
      rem_q  <= ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign root_o = root_q;

endmodule

// ----- design/kcv_dp.sv -----
// ----------------------------------------------------------------------------
// kcv_dp: filter datapath
// State and config registers, shared multiplier, divider, square root and
// the output register, all steered by commands from the controller.
// ----------------------------------------------------------------------------
module kcv_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic signed [31:0]          meas_x_i,
  input  logic signed [31:0]          meas_y_i,
  input  logic signed [31:0]          meas_z_i,
  input  logic                        cfg_we_i,
  input  logic [kcv_pkg::CIW-1:0]     cfg_idx_i,
  input  logic [kcv_pkg::CW-1:0]      cfg_data_i,
  input  kcv_pkg::cmd_t               cmd_i,
  output kcv_pkg::stat_t              stat_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic signed [31:0]          out_x_o,
  output logic signed [31:0]          out_y_o,
  output logic signed [31:0]          out_z_o,
  output logic                        meas_used_o
);
  import kcv_pkg::*;

  // saturate a wide signed sum to the state width
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    if (v > hi) return hi[DW-1:0];
    else if (v < lo) return lo[DW-1:0];
    else return v[DW-1:0];
  endfunction

  // signed value from a magnitude and a sign, saturated
  function automatic logic signed [DW-1:0] sat_mag(input logic [QW-1:0] m, input logic neg);
    logic over;
    over = m[QW-1:DW-1] != '0;
    if (over) return neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    else return neg ? DW'(~m[DW-1:0] + DW'(1)) : m[DW-1:0];
  endfunction

  function automatic logic [MW-1:0] mag_dw(input logic signed [DW-1:0] v);
    logic signed [MW-1:0] e;
    e = MW'(v);
    return e[MW-1] ? MW'(-e) : MW'(e);
  endfunction

  function automatic logic [MW-1:0] mag_dd(input logic signed [MW-1:0] v);
    return v[MW-1] ? MW'(-v) : MW'(v);
  endfunction

  // config
  logic [CW-1:0] pn_q, mn_q;
  logic [JW-1:0] mj_q, ms_q;

  // filter state
  logic signed [DW-1:0] pos_q [3];
  logic signed [DW-1:0] vel_q [3];
  logic signed [DW-1:0] last_q [3];
  logic signed [DW-1:0] pp_q, pv_q, vv_q;
  logic                 seeded_q;

  // working registers
  logic signed [DW-1:0] m_q [3];
  logic signed [DW-1:0] f_q [3];
  logic signed [MW-1:0] dd_q [3];
  logic signed [DW-1:0] kp_q, kv_q;
  logic [PW-1:0]        prod_q, acc_q;
  logic                 prod_neg_q;
  logic [RW-1:0]        nrm_q;
  logic                 used_q;

  // output register
  logic                 out_valid_q;
  logic signed [DW-1:0] out_x_q, out_y_q, out_z_q;
  logic                 out_used_q;

  // combinational helpers
  logic [MW-1:0]        mul_a, mul_b;
  logic                 mul_neg;
  logic [PW-1:0]        mul_p;
  logic signed [DW-1:0] mq;
  logic signed [SW-1:0] pn_sx, s_sum;
  logic signed [DW-1:0] meas [3];
  logic                 div_start, div_busy;
  logic [QW-1:0]        div_num, div_quot;
  logic [DVW-1:0]       div_den;
  logic                 sqrt_busy;
  logic [RW-1:0]        sqrt_root;
  logic                 out_free;

  assign meas[0] = sat_dw(SW'(meas_x_i));
  assign meas[1] = sat_dw(SW'(meas_y_i));
  assign meas[2] = sat_dw(SW'(meas_z_i));

  assign pn_sx = SW'($signed({1'b0, pn_q}));
  assign s_sum = SW'(pp_q) + SW'($signed({1'b0, mn_q}));
  assign mq    = sat_mag(QW'(prod_q[PW-1:FB]), prod_neg_q);

  // multiplier operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd_i.msel)
      M_SQD: begin
        mul_a = mag_dd(dd_q[cmd_i.max]);
        mul_b = mag_dd(dd_q[cmd_i.max]);
      end
      M_JMP: begin
        mul_a = MW'(mj_q);
        mul_b = MW'(mj_q);
      end
      M_STP: begin
        mul_a = MW'(ms_q);
        mul_b = MW'(ms_q);
      end
      M_KPD: begin
        mul_a   = mag_dw(kp_q);
        mul_b   = mag_dd(dd_q[cmd_i.max]);
        mul_neg = kp_q[DW-1] ^ dd_q[cmd_i.max][MW-1];
      end
      M_KVD: begin
        mul_a   = mag_dw(kv_q);
        mul_b   = mag_dd(dd_q[cmd_i.max]);
        mul_neg = kv_q[DW-1] ^ dd_q[cmd_i.max][MW-1];
      end
      M_KVPV: begin
        mul_a   = mag_dw(kv_q);
        mul_b   = mag_dw(pv_q);
        mul_neg = kv_q[DW-1] ^ pv_q[DW-1];
      end
      M_KPPP: begin
        mul_a   = mag_dw(kp_q);
        mul_b   = mag_dw(pp_q);
        mul_neg = kp_q[DW-1] ^ pp_q[DW-1];
      end
      M_KPPV: begin
        mul_a   = mag_dw(kp_q);
        mul_b   = mag_dw(pv_q);
        mul_neg = kp_q[DW-1] ^ pv_q[DW-1];
      end
      M_DSTEP: begin
        mul_a = mag_dd(dd_q[cmd_i.max]);
        mul_b = MW'(ms_q);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = s_sum[DVW-1:0];
    case (cmd_i.act)
      A_DIVKP: begin
        div_start = 1'b1;
        div_num   = QW'(mag_dw(pp_q)) << FB;
      end
      A_DIVKV: begin
        div_start = 1'b1;
        div_num   = QW'(mag_dw(pv_q)) << FB;
      end
      A_DIVSTP: begin
        div_start = 1'b1;
        div_num   = prod_q[QW-1:0];
        div_den   = DVW'(nrm_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  kcv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  kcv_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.act == A_SQRT),
    .rad_i   (acc_q),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // config, filter state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q        <= PNOISE_RST;
      mn_q        <= MNOISE_RST;
      mj_q        <= MJUMP_RST;
      ms_q        <= MSTEP_RST;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]  <= '0;
        vel_q[i]  <= '0;
        last_q[i] <= '0;
      end
      pp_q        <= DW'(1) << FB;
      pv_q        <= '0;
      vv_q        <= DW'(1) << FB;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // config writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PNOISE: pn_q <= cfg_data_i;
          REG_MNOISE: mn_q <= cfg_data_i;
          REG_MJUMP:  mj_q <= cfg_data_i[JW-1:0];
          REG_MSTEP:  ms_q <= cfg_data_i[JW-1:0];
          default: begin
            pn_q <= pn_q;
          end
        endcase
      end

      // state actions
      case (cmd_i.act)
        A_SEED: begin
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= m_q[i];
            vel_q[i] <= '0;
          end
          seeded_q <= 1'b1;
        end
        A_PRED: begin
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= sat_dw(SW'(pos_q[i]) + SW'(vel_q[i]));
          end
          pp_q <= sat_dw(SW'(pp_q) + SW'(pv_q) + SW'(pv_q) + SW'(vv_q) + pn_sx);
          pv_q <= sat_dw(SW'(pv_q) + SW'(vv_q));
          vv_q <= sat_dw(SW'(vv_q) + pn_sx);
        end
        A_COMMIT: begin
          for (int i = 0; i < 3; i++) begin
            last_q[i] <= f_q[i];
          end
        end
        default: begin
          seeded_q <= seeded_q;
        end
      endcase

      // product write-back into state
      case (cmd_i.wsel)
        W_EPOS: pos_q[cmd_i.wax] <= sat_dw(SW'(pos_q[cmd_i.wax]) + SW'(mq));
        W_EVEL: vel_q[cmd_i.wax] <= sat_dw(SW'(vel_q[cmd_i.wax]) + SW'(mq));
        W_VV:   vv_q <= sat_dw(SW'(vv_q) - SW'(mq));
        W_PP:   pp_q <= sat_dw(SW'(pp_q) - SW'(mq));
        W_PV:   pv_q <= sat_dw(SW'(pv_q) - SW'(mq));
        default: ;
      endcase

      // output beat
      if (cmd_i.act == A_COMMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers and output payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i] <= meas[i];
      end
      used_q <= 1'b1;
    end

    if (cmd_i.msel != M_NONE) begin
      prod_q     <= mul_p;
      prod_neg_q <= mul_neg;
    end

    case (cmd_i.wsel)
      W_ACCL:  acc_q <= prod_q;
      W_ACC:   acc_q <= acc_q + prod_q;
      default: begin
        acc_q <= acc_q;
      end
    endcase

    case (cmd_i.act)
      A_SEED: begin
        for (int i = 0; i < 3; i++) begin
          f_q[i] <= m_q[i];
        end
      end
      A_DIFF_M: begin
        for (int i = 0; i < 3; i++) begin
          dd_q[i] <= MW'(m_q[i]) - MW'(pos_q[i]);
        end
      end
      A_REJECT: used_q <= 1'b0;
      A_KPSAVE: kp_q <= sat_mag(div_quot, pp_q[DW-1]);
      A_KVSAVE: kv_q <= sat_mag(div_quot, pv_q[DW-1]);
      A_DIFF_F: begin
        for (int i = 0; i < 3; i++) begin
          dd_q[i] <= MW'(pos_q[i]) - MW'(last_q[i]);
          f_q[i]  <= pos_q[i];
        end
      end
      A_NRMSAVE: nrm_q <= sqrt_root;
      A_STPSAVE: begin
        f_q[cmd_i.max] <= sat_dw(SW'(last_q[cmd_i.max])
                          + SW'(sat_mag(div_quot, dd_q[cmd_i.max][MW-1])));
      end
      A_COMMIT: begin
        out_x_q    <= f_q[0];
        out_y_q    <= f_q[1];
        out_z_q    <= f_q[2];
        out_used_q <= used_q;
      end
      default: begin
        nrm_q <= nrm_q;
      end
    endcase
  end

  // status back to the controller
  assign stat_o.seeded      = seeded_q;
  assign stat_o.acc_lt_prod = acc_q < prod_q;
  assign stat_o.prod_lt_acc = prod_q < acc_q;
  assign stat_o.s_pos       = s_sum > 0;
  assign stat_o.div_busy    = div_busy;
  assign stat_o.sqrt_busy   = sqrt_busy;
  assign stat_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign meas_used_o = out_used_q;

endmodule

// ----- design/kcv_ctrl.sv -----
// ----------------------------------------------------------------------------
// kcv_ctrl: filter sequencer
// Walks seed / predict / gate / correct / clamp and issues datapath commands.
// ----------------------------------------------------------------------------
module kcv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  kcv_pkg::stat_t  stat_i,
  output kcv_pkg::cmd_t   cmd_o,
  output logic            busy_o
);
  import kcv_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SEED, S_PRED, S_DIFFM, S_SQ0, S_SQ1, S_SQ2, S_SQL, S_CMP,
    S_SCHK, S_DIVKP, S_WKP, S_DIVKV, S_WKV, S_CKP, S_CKV, S_CVV, S_CPP,
    S_CPV, S_CPW, S_DIFFF, S_ROOT, S_WROOT, S_SMUL, S_SDIV, S_SWAIT, S_COMMIT
  } state_e;

  state_e     state_q;
  logic [1:0] axis_q;
  logic       phase_q;  // 0: gate check, 1: step clamp check

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= AX_X;
      phase_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= stat_i.seeded ? S_PRED : S_SEED;
        S_SEED:   state_q <= S_COMMIT;
        S_PRED: begin
          phase_q <= 1'b0;
          state_q <= S_DIFFM;
        end
        S_DIFFM:  state_q <= S_SQ0;
        S_SQ0:    state_q <= S_SQ1;
        S_SQ1:    state_q <= S_SQ2;
        S_SQ2:    state_q <= S_SQL;
        S_SQL:    state_q <= S_CMP;
        S_CMP: begin
          if (!phase_q) state_q <= stat_i.acc_lt_prod ? S_SCHK : S_DIFFF;
          else state_q <= stat_i.prod_lt_acc ? S_ROOT : S_COMMIT;
        end
        S_SCHK:   state_q <= stat_i.s_pos ? S_DIVKP : S_DIFFF;
        S_DIVKP:  state_q <= S_WKP;
        S_WKP:    if (!stat_i.div_busy) state_q <= S_DIVKV;
        S_DIVKV:  state_q <= S_WKV;
        S_WKV: begin
          if (!stat_i.div_busy) begin
            axis_q  <= AX_X;
            state_q <= S_CKP;
          end
        end
        S_CKP:    state_q <= S_CKV;
        S_CKV: begin
          if (axis_q == AX_Z) begin
            state_q <= S_CVV;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_CKP;
          end
        end
        S_CVV:    state_q <= S_CPP;
        S_CPP:    state_q <= S_CPV;
        S_CPV:    state_q <= S_CPW;
        S_CPW:    state_q <= S_DIFFF;
        S_DIFFF: begin
          phase_q <= 1'b1;
          state_q <= S_SQ0;
        end
        S_ROOT:   state_q <= S_WROOT;
        S_WROOT: begin
          if (!stat_i.sqrt_busy) begin
            axis_q  <= AX_X;
            state_q <= S_SMUL;
          end
        end
        S_SMUL:   state_q <= S_SDIV;
        S_SDIV:   state_q <= S_SWAIT;
        S_SWAIT: begin
          if (!stat_i.div_busy) begin
            if (axis_q == AX_Z) begin
              state_q <= S_COMMIT;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_SMUL;
            end
          end
        end
        S_COMMIT: if (stat_i.out_free) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o.act  = A_NONE;
    cmd_o.msel = M_NONE;
    cmd_o.max  = axis_q;
    cmd_o.wsel = W_NONE;
    cmd_o.wax  = axis_q;
    case (state_q)
      S_SEED:  cmd_o.act = A_SEED;
      S_PRED:  cmd_o.act = A_PRED;
      S_DIFFM: cmd_o.act = A_DIFF_M;
      S_SQ0: begin
        cmd_o.msel = M_SQD;
        cmd_o.max  = AX_X;
      end
      S_SQ1: begin
        cmd_o.msel = M_SQD;
        cmd_o.max  = AX_Y;
        cmd_o.wsel = W_ACCL;
      end
      S_SQ2: begin
        cmd_o.msel = M_SQD;
        cmd_o.max  = AX_Z;
        cmd_o.wsel = W_ACC;
      end
      S_SQL: begin
        cmd_o.msel = phase_q ? M_STP : M_JMP;
        cmd_o.wsel = W_ACC;
      end
      S_CMP:   if (!phase_q && !stat_i.acc_lt_prod) cmd_o.act = A_REJECT;
      S_DIVKP: cmd_o.act = A_DIVKP;
      S_WKP:   if (!stat_i.div_busy) cmd_o.act = A_KPSAVE;
      S_DIVKV: cmd_o.act = A_DIVKV;
      S_WKV:   if (!stat_i.div_busy) cmd_o.act = A_KVSAVE;
      S_CKP: begin
        cmd_o.msel = M_KPD;
        if (axis_q != AX_X) begin
          cmd_o.wsel = W_EVEL;
          cmd_o.wax  = axis_q - 2'd1;
        end
      end
      S_CKV: begin
        cmd_o.msel = M_KVD;
        cmd_o.wsel = W_EPOS;
      end
      S_CVV: begin
        cmd_o.msel = M_KVPV;
        cmd_o.wsel = W_EVEL;
      end
      S_CPP: begin
        cmd_o.msel = M_KPPP;
        cmd_o.wsel = W_VV;
      end
      S_CPV: begin
        cmd_o.msel = M_KPPV;
        cmd_o.wsel = W_PP;
      end
      S_CPW:   cmd_o.wsel = W_PV;
      S_DIFFF: cmd_o.act = A_DIFF_F;
      S_ROOT:  cmd_o.act = A_SQRT;
      S_WROOT: if (!stat_i.sqrt_busy) cmd_o.act = A_NRMSAVE;
      S_SMUL:  cmd_o.msel = M_DSTEP;
      S_SDIV:  cmd_o.act = A_DIVSTP;
      S_SWAIT: if (!stat_i.div_busy) cmd_o.act = A_STPSAVE;
      S_COMMIT: if (stat_i.out_free) cmd_o.act = A_COMMIT;
      default: cmd_o.act = A_NONE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;

endmodule

// ----- dv/kalman_cv3d_gated_rate_limited_tb.sv -----
// ----------------------------------------------------------------------------
// kalman_cv3d_gated_rate_limited_tb: self-checking bench for the 3D tracker
// Drives measurement beats through a stall-aware driver, predicts each
// filtered position with an in-bench fixed-point tracker model and checks
// every output beat in order, across several register settings.
// ----------------------------------------------------------------------------
module kalman_cv3d_gated_rate_limited_tb;
  import kcv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam longint ONE_Q   = 64'sd65536;
  localparam int     HOLD_CYCLES = 300;
  localparam int     IDLE_LIMIT  = 20000;
  localparam int     DRAIN_CYCLES = 500;

  typedef struct {
    logic signed [31:0] x, y, z;
  } meas_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               used;
  } fix_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] meas_x_i = '0;
  logic signed [31:0] meas_y_i = '0;
  logic signed [31:0] meas_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic               meas_used_o;
  logic               cfg_we_i = 1'b0;
  logic [CIW-1:0]     cfg_idx_i = REG_PNOISE;
  logic [CW-1:0]      cfg_data_i = '0;

  kalman_cv3d_gated_rate_limited dut (.*);

  // tracker model state
  longint trk_est[6];
  longint trk_pp, trk_pv, trk_vv;
  longint trk_last[3];
  bit     trk_seeded;
  longint reg_pnoise, reg_mnoise, reg_mjump, reg_mstep;

  meas_t  meas_pending[$];
  fix_t   fix_expected[$];
  meas_t  meas_on_port;
  int     err_cnt = 0;
  bit     quiet = 1'b0;
  int     hold_trig = 0;

  // scene used by the random tracks
  longint scene_pos[3];
  longint scene_vel[3];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- math
  function automatic longint clip(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic logic [127:0] absw(longint v);
    logic [127:0] r;
    r = (v < 0) ? 128'(-v) : 128'(v);
    return r;
  endfunction

  function automatic longint clip_mag(logic [127:0] m, bit neg);
    if (neg) return (m >= 128'd2147483648) ? POS_MIN : -longint'(m[63:0]);
    return (m >= 128'd2147483648) ? POS_MAX : longint'(m[63:0]);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    p = (absw(a) * absw(b)) >> FB;
    return clip_mag(p, (a < 0) != (b < 0));
  endfunction

  function automatic longint qdiv(longint a, longint b);
    logic [127:0] q;
    q = (absw(a) << FB) / 128'(b);
    return clip_mag(q, a < 0);
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] n);
    logic [127:0] res, c;
    res = '0;
    for (int b = 50; b >= 0; b--) begin
      c = res | (128'd1 << b);
      if (c * c <= n) res = c;
    end
    return res;
  endfunction

  function automatic logic [127:0] norm2(longint d[3]);
    return absw(d[0]) * absw(d[0]) + absw(d[1]) * absw(d[1]) + absw(d[2]) * absw(d[2]);
  endfunction

  // one measurement through the tracker; queues the filtered position
  task automatic track_meas(meas_t mv);
    longint m[3], d[3], filt[3];
    longint s_var, kp, kv, pp, pv, vv;
    logic [127:0] s2, nrm, q;
    fix_t f;
    f.used = 1'b1;
    m[0] = mv.x; m[1] = mv.y; m[2] = mv.z;
    if (!trk_seeded) begin
      for (int i = 0; i < 3; i++) begin
        trk_est[i] = m[i];
        trk_est[i+3] = 0;
        trk_last[i] = m[i];
        filt[i] = m[i];
      end
      trk_seeded = 1'b1;
    end else begin
      pp = trk_pp; pv = trk_pv; vv = trk_vv;
      for (int i = 0; i < 3; i++) trk_est[i] = clip(trk_est[i] + trk_est[i+3]);
      pp = clip(pp + 2 * pv + vv + reg_pnoise);
      pv = clip(pv + vv);
      vv = clip(vv + reg_pnoise);
      for (int i = 0; i < 3; i++) d[i] = m[i] - trk_est[i];
      // gate: strictly inside max_jump
      if (norm2(d) < 128'(reg_mjump) * 128'(reg_mjump)) begin
        s_var = pp + reg_mnoise;
        kp = 0;
        kv = 0;
        if (s_var > 0) begin
          kp = qdiv(pp, s_var);
          kv = qdiv(pv, s_var);
        end
        for (int i = 0; i < 3; i++) begin
          trk_est[i]   = clip(trk_est[i] + qmul(kp, d[i]));
          trk_est[i+3] = clip(trk_est[i+3] + qmul(kv, d[i]));
        end
        vv = clip(vv - qmul(kv, pv));
        pp = clip(pp - qmul(kp, pp));
        pv = clip(pv - qmul(kp, pv));
      end else begin
        f.used = 1'b0;
      end
      trk_pp = pp; trk_pv = pv; trk_vv = vv;
      for (int i = 0; i < 3; i++) begin
        filt[i] = trk_est[i];
        d[i] = filt[i] - trk_last[i];
      end
      // step clamp, direction kept
      s2 = norm2(d);
      if (128'(reg_mstep) * 128'(reg_mstep) < s2) begin
        nrm = isqrt(s2);
        for (int i = 0; i < 3; i++) begin
          q = (absw(d[i]) * 128'(reg_mstep)) / nrm;
          filt[i] = clip(trk_last[i] + clip_mag(q, d[i] < 0));
        end
      end
      for (int i = 0; i < 3; i++) trk_last[i] = filt[i];
    end
    f.x = filt[0][31:0];
    f.y = filt[1][31:0];
    f.z = filt[2][31:0];
    fix_expected.push_back(f);
  endtask

  // ---------------------------------------------------------------- driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) track_meas(meas_on_port);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (meas_pending.size() > 0) begin
          if (!quiet && $urandom_range(0, 4) == 0) begin
            send_gap <= $urandom_range(0, 5);
            in_valid_i <= 1'b0;
          end else begin
            meas_on_port = meas_pending.pop_front();
            meas_x_i <= meas_on_port.x;
            meas_y_i <= meas_on_port.y;
            meas_z_i <= meas_on_port.z;
            in_valid_i <= 1'b1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    fix_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (fix_expected.size() == 0) begin
          $error("output beat with nothing expected: x=%0d y=%0d z=%0d used=%0b",
                 out_x_o, out_y_o, out_z_o, meas_used_o);
          err_cnt++;
        end else begin
          e = fix_expected.pop_front();
          if (out_x_o !== e.x) begin
            $error("out_x: expected %0d, got %0d", e.x, out_x_o); err_cnt++;
          end
          if (out_y_o !== e.y) begin
            $error("out_y: expected %0d, got %0d", e.y, out_y_o); err_cnt++;
          end
          if (out_z_o !== e.z) begin
            $error("out_z: expected %0d, got %0d", e.z, out_z_o); err_cnt++;
          end
          if (meas_used_o !== e.used) begin
            $error("meas_used: expected %0b, got %0b", e.used, meas_used_o); err_cnt++;
          end
        end
      end
      // receiver back-pressure: long hold-off on request, else short bursts
      if (hold_seen != hold_trig) begin
        hold_seen++;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int idle_cnt = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (meas_pending.size() == 0 && fix_expected.size() == 0 && !in_valid_i)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("kalman_cv3d_gated_rate_limited: mismatch");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(logic [CIW-1:0] idx, logic [CW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_PNOISE: reg_pnoise = longint'(val);
      REG_MNOISE: reg_mnoise = longint'(val);
      REG_MJUMP:  reg_mjump  = longint'(val[JW-1:0]);
      REG_MSTEP:  reg_mstep  = longint'(val[JW-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CW-1:0] pn, logic [CW-1:0] mn,
                          logic [CW-1:0] mj, logic [CW-1:0] ms);
    write_reg(REG_PNOISE, pn);
    write_reg(REG_MNOISE, mn);
    write_reg(REG_MJUMP, mj);
    write_reg(REG_MSTEP, ms);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (meas_pending.size() != 0 || fix_expected.size() != 0 || in_valid_i ||
           in_stall_o)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_meas(longint x, longint y, longint z);
    meas_t mv;
    mv.x = 32'(clip(x));
    mv.y = 32'(clip(y));
    mv.z = 32'(clip(z));
    meas_pending.push_back(mv);
  endtask

  // mostly a plausible moving target with noise; some outliers and jumps
  task automatic push_track(int n, int noise_bits);
    longint nz[3];
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 29) == 0) begin
        for (int i = 0; i < 3; i++) scene_vel[i] = $signed($urandom_range(0, 262143)) - 131072;
      end
      if ($urandom_range(0, 59) == 0) begin
        for (int i = 0; i < 3; i++) scene_pos[i] = longint'($signed($urandom()));
      end
      for (int i = 0; i < 3; i++) begin
        scene_pos[i] = clip(scene_pos[i] + scene_vel[i]);
        nz[i] = $signed($urandom_range(0, (1 << noise_bits) - 1)) - (1 << (noise_bits - 1));
      end
      case ($urandom_range(0, 19))
        0:       push_meas($signed($urandom()), $signed($urandom()), $signed($urandom()));
        1:       push_meas(($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN,
                           scene_pos[1] + nz[1],
                           ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN);
        2:       push_meas(scene_pos[0] + 2 * nz[0] * 64, scene_pos[1], scene_pos[2]);
        default: push_meas(scene_pos[0] + nz[0], scene_pos[1] + nz[1], scene_pos[2] + nz[2]);
      endcase
    end
  endtask

  initial begin
    trk_est = '{default: 0};
    trk_last = '{default: 0};
    trk_pp = ONE_Q; trk_pv = 0; trk_vv = ONE_Q;
    trk_seeded = 1'b0;
    reg_pnoise = PNOISE_RST;
    reg_mnoise = MNOISE_RST;
    reg_mjump  = MJUMP_RST;
    reg_mstep  = MSTEP_RST;
    scene_pos = '{default: 0};
    scene_vel = '{default: 0};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: seed at extremes on reset registers, then edge cases
    push_meas(POS_MAX, POS_MIN, 0);
    push_meas(POS_MAX, POS_MIN, 0);            // zero innovation
    push_meas(POS_MIN, POS_MAX, -1);           // far jump, gated out
    push_meas(POS_MAX - ONE_Q, POS_MIN + ONE_Q, 3 * ONE_Q);  // small move inside the gate and under the step limit
    push_meas(POS_MAX, POS_MIN, 0);
    push_meas(0, 0, 0);
    wait_drained();

    // zero gate and zero step: equal distance rejects; every move clamps
    set_regs(32'd0, 32'd0, 32'd0, 32'd0);
    push_meas(0, 0, 0);
    push_meas(ONE_Q, -ONE_Q, 5);
    push_meas(0, 0, 0);
    wait_drained();

    // no noise at all and a wide gate: zero innovation variance reachable
    set_regs(32'd0, 32'd0, 32'h7fff_ffff, 32'h7fff_ffff);
    for (int k = 0; k < 6; k++) push_meas(k * ONE_Q, -k * ONE_Q, 7);
    push_meas(POS_MIN, POS_MAX, POS_MIN);
    push_meas(POS_MAX, POS_MIN, POS_MAX);
    wait_drained();

    // random: reset-value registers, then sender pause and a long hold-off
    set_regs(PNOISE_RST, MNOISE_RST, 32'(MJUMP_RST), 32'(MSTEP_RST));
    push_track(130, 16);
    wait_drained();
    hold_trig = 1;
    push_track(140, 16);
    wait_drained();

    // largest noise registers, tight gate and step
    set_regs(32'hffff_ffff, 32'hffff_ffff, 32'd1 << 20, 32'd1 << 18);
    push_track(270, 14);
    wait_drained();

    // widest limits, low noise
    set_regs(32'd1, 32'd300, 32'h7fff_ffff, 32'h7fff_ffff);
    push_track(270, 18);
    wait_drained();

    // random register values
    set_regs($urandom(), $urandom(), $urandom_range(65536, 32'h7fff_ffff),
             $urandom_range(0, 32'h7fff_ffff));
    push_track(270, 16);
    wait_drained();

    set_regs($urandom_range(0, 4096), $urandom_range(0, 65536),
             $urandom_range(1 << 19, 1 << 24), $urandom_range(1 << 14, 1 << 20));
    push_track(270, 17);
    wait_drained();

    // last part without idling on either side
    quiet = 1'b1;
    set_regs(PNOISE_RST, MNOISE_RST, 32'(MJUMP_RST), 32'(MSTEP_RST));
    push_track(270, 16);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && fix_expected.size() == 0)
      $display("kalman_cv3d_gated_rate_limited: match");
    else
      $display("kalman_cv3d_gated_rate_limited: mismatch");
    $finish;
  end

endmodule
